[design/mtd_pkg.sv]
// shared types, constants and helper functions of the morse token decoder
package mtd_pkg;

	// tree geometry
	localparam int TREE_LEVELS  = 7;
	localparam int TABLE_DEPTH  = 255;
	localparam int ADDR_W       = 8;
	localparam int MAX_CODE_LEN_DEF = 7;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// item function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_CHAR   = 2'd0;
	localparam logic [1:0] KIND_LOADED = 2'd1;
	localparam logic [1:0] KIND_DUP    = 2'd2;

	// character codes
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	// input item
	typedef struct packed {
		logic       func;
		logic [7:0] ch;
		logic [6:0] code_bits;
		logic [2:0] code_len;
		logic       final_req;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_char;
		logic       last;
	} out_item_t;

	// classified operation passed from front to back
	typedef struct packed {
		logic              is_load;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        letter;  // load letter, or fixed char when no lookup
		logic              lookup;
		logic              nl;      // newline follows the token char
	} op_t;

	// whitespace test
	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
			(c == CH_VT) || (c == CH_FF) || (c == CH_CR);
	endfunction

	// heap index of a load pattern
	function automatic logic [ADDR_W-1:0] load_index(input logic [6:0] bits,
		input logic [2:0] len);
		logic [ADDR_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < TREE_LEVELS; i++) begin
			if (3'(i) < len) begin
				idx = {idx[ADDR_W-2:0], 1'b0} + (bits[i] ? 8'd2 : 8'd1);
			end
		end
		return idx;
	endfunction

endpackage

[design/mtd_ram.sv]
// generic single-write, single-read ram with registered read data
module mtd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 255
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/mtd_front.sv]
// front end: accepts items, tracks the open token and classifies into operations
module mtd_front #(
	parameter int MAX_CODE_LEN = mtd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  mtd_pkg::in_item_t item,
	output logic              op_push,
	output mtd_pkg::op_t      op
);
	import mtd_pkg::*;

	localparam int TLW = $clog2(MAX_CODE_LEN + 2);

	typedef struct packed {
		logic              in_tok;
		logic              slash;
		logic              stopped;
		logic              ovf;
		logic [ADDR_W-1:0] idx;
		logic [2:0]        depth;
		logic [TLW-1:0]    len;
	} tok_t;

	tok_t tok_q;
	tok_t take;
	tok_t sel;
	tok_t nxt;
	logic blank;
	logic emit;

	// token walk for one byte and operation build
	always_comb begin
		blank = is_blank(item.ch);
		take = tok_q;
		take.in_tok = 1'b1;
		if (!tok_q.in_tok) begin
			take.slash = (item.ch == CH_SLASH);
		end
		if (tok_q.len <= TLW'(MAX_CODE_LEN)) begin
			take.len = tok_q.len + 1'b1;
		end
		if (take.len > TLW'(MAX_CODE_LEN)) begin
			take.ovf = 1'b1;
		end
		if (!tok_q.stopped) begin
			if (item.ch != CH_DOT && item.ch != CH_DASH) begin
				take.stopped = 1'b1;
			end else if (tok_q.depth >= 3'(TREE_LEVELS)) begin
				take.ovf     = 1'b1;
				take.stopped = 1'b1;
			end else begin
				take.idx   = {tok_q.idx[ADDR_W-2:0], 1'b0} +
					((item.ch == CH_DASH) ? 8'd2 : 8'd1);
				take.depth = tok_q.depth + 3'd1;
			end
		end

		sel  = blank ? tok_q : take;
		emit = blank ? tok_q.in_tok : item.final_req;
		nxt  = emit ? '0 : sel;

		if (item.func == FUNC_LOAD) begin
			op_push    = 1'b1;
			op.is_load = 1'b1;
			op.addr    = load_index(item.code_bits, item.code_len);
			op.letter  = item.ch;
			op.lookup  = 1'b1;
			op.nl      = 1'b0;
		end else begin
			op_push    = emit;
			op.is_load = 1'b0;
			op.addr    = sel.idx;
			op.letter  = sel.slash ? CH_SPACE : CH_HASH;
			op.lookup  = !sel.slash && !sel.ovf;
			op.nl      = blank && (item.ch == CH_LF);
		end
	end

	// token state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (accept && item.func == FUNC_DECODE) begin
			tok_q <= nxt;
		end
	end

endmodule

[design/mtd_queue.sv]
// small queue of classified operations between front and back
module mtd_queue #(
	parameter int DEPTH = mtd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  mtd_pkg::op_t din,
	output logic         full,
	output logic         valid,
	input  logic         take,
	output mtd_pkg::op_t dout
);
	import mtd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = take && valid;
	assign dout    = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/mtd_back.sv]
// back end: table lookup and update, result generation
module mtd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	input  mtd_pkg::op_t       op,
	output logic               op_take,
	output logic               empty,
	input  logic               pop,
	output mtd_pkg::out_item_t result
);
	import mtd_pkg::*;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} byp_t;

	logic [TABLE_DEPTH-1:0] used_q;
	logic                   load_failed_q;
	logic                   valid_s2;
	logic                   phase_q;
	op_t                    op_s2;
	logic                   used_s2;
	byp_t                   byp_s2;
	logic                   byp_valid_s2;
	logic [7:0]             rdata;
	logic                   hit;
	logic                   eff_used;
	logic [7:0]             eff_data;
	logic                   letter_nz;
	logic                   drop;
	logic                   has_out;
	logic                   pop_fire;
	logic                   done;
	logic                   wr_en;

	// code table
	mtd_ram #(
		.WIDTH(8),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.re    (op_take),
		.raddr (op.addr),
		.rdata (rdata),
		.we    (wr_en),
		.waddr (op_s2.addr),
		.wdata (op_s2.letter)
	);

	// lookup with forwarding of the write made as this item was read
	always_comb begin
		hit       = byp_valid_s2 && (byp_s2.addr == op_s2.addr);
		eff_used  = hit || used_s2;
		eff_data  = hit ? byp_s2.data : rdata;
		letter_nz = eff_used && (eff_data != CH_NUL);
	end

	// result selection
	always_comb begin
		drop     = valid_s2 && !op_s2.is_load && load_failed_q;
		has_out  = valid_s2 && !drop;
		empty    = !has_out;
		result   = '0;
		if (op_s2.is_load) begin
			result.kind     = letter_nz ? KIND_DUP : KIND_LOADED;
			result.out_char = CH_NUL;
			result.last     = 1'b1;
		end else if (phase_q) begin
			result.kind     = KIND_CHAR;
			result.out_char = CH_LF;
			result.last     = 1'b1;
		end else begin
			result.kind     = KIND_CHAR;
			result.out_char = !op_s2.lookup ? op_s2.letter :
				(letter_nz ? eff_data : CH_HASH);
			result.last     = !op_s2.nl;
		end
		pop_fire = pop && has_out;
		done     = drop || (pop_fire && result.last);
		op_take  = op_valid && (!valid_s2 || done);
		wr_en    = valid_s2 && op_s2.is_load && pop_fire && !letter_nz;
	end

	// stage payload and forwarding capture
	always_ff @(posedge clk) begin
		if (op_take) begin
			op_s2        <= op;
			used_s2      <= used_q[op.addr];
			byp_s2.addr  <= op_s2.addr;
			byp_s2.data  <= op_s2.letter;
		end
	end

	// stage control, entry valid bits and sticky refusal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2      <= 1'b0;
			phase_q       <= 1'b0;
			byp_valid_s2  <= 1'b0;
			used_q        <= '0;
			load_failed_q <= 1'b0;
		end else begin
			if (op_take) begin
				valid_s2     <= 1'b1;
				byp_valid_s2 <= wr_en;
			end else if (done) begin
				valid_s2 <= 1'b0;
			end
			if (done) begin
				phase_q <= 1'b0;
			end else if (pop_fire) begin
				phase_q <= 1'b1;
			end
			if (wr_en) begin
				used_q[op_s2.addr] <= 1'b1;
			end
			if (valid_s2 && op_s2.is_load && pop_fire && letter_nz) begin
				load_failed_q <= 1'b1;
			end
		end
	end

endmodule

[design/morse_token_decoder_unit.sv]
// top level of the morse token decoder
//
// Input queue side: an item (load a table entry, or decode one byte) is taken
// at a clock edge with push high and full low. Result queue side: the oldest
// result is on the result port while empty is low and is taken at an edge
// with pop high and empty low.
// An accepted item is written into the operation queue and then into the lookup stage, from which its result is popped.
// Throughput: one item per cycle while full is low; an item that gives two results (token
// char and newline) holds the lookup stage for two pops, and a decode item
// that closes no token gives no result and never reaches the back end.
// The rate is set by the single table read port: each operation does one
// table read, and a load writes the same entry when its result is popped.
// When pop stays low, the lookup stage holds, the operation queue fills and
// full rises; nothing is lost.
// Reset clears the token state, the queue, the sticky refusal flag and the
// per-entry valid bits of the code table at once; no clearing pass is needed.
module morse_token_decoder_unit #(
	parameter int MAX_CODE_LEN = mtd_pkg::MAX_CODE_LEN_DEF,
	parameter int QUEUE_DEPTH  = mtd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  mtd_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output mtd_pkg::out_item_t result
);
	import mtd_pkg::*;

	logic accept;
	logic op_push;
	op_t  op_in;
	logic op_valid;
	logic op_take;
	op_t  op_head;

	assign accept = push && !full;

	// classification
	mtd_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.op_push (op_push),
		.op      (op_in)
	);

	// decoupling queue
	mtd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept && op_push),
		.din    (op_in),
		.full   (full),
		.valid  (op_valid),
		.take   (op_take),
		.dout   (op_head)
	);

	// table access and results
	mtd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (op_valid),
		.op       (op_head),
		.op_take  (op_take),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

[verif/tb_top.sv]
// testbench for the morse token decoder: random queue traffic checked against a built-in predictor
module tb_top;
	import mtd_pkg::*;

	localparam int MAX_LEN     = MAX_CODE_LEN_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int CALM_ITEMS  = 150;
	localparam int RANDOM_END  = 1240;
	localparam int STREAM_END  = 1300;
	localparam int MAX_REPORTS = 50;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      full;
	in_item_t  item   = '0;
	logic      empty;
	logic      pop    = 1'b0;
	out_item_t result;

	// predictor state
	logic [7:0] tree_letter [TABLE_DEPTH];
	logic [7:0] walk_idx;
	int         walk_depth;
	int         token_count;
	logic       token_open;
	logic       token_slash;
	logic       walk_halted;
	logic       token_long;
	logic       refused;

	// stimulus and expected results
	in_item_t   pending_items [$];
	out_item_t  expected_results [$];
	out_item_t  want_result;
	bit         slot_used [TABLE_DEPTH];
	logic [7:0] blanks [6];

	int errors    = 0;
	int cycles    = 0;
	int send_idle = 0;
	int pop_stall = 0;

	morse_token_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic is_space_byte(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
			c == CH_CR;
	endfunction

	// heap position of a code pattern: dot child 2i+1, dash child 2i+2
	function automatic logic [7:0] heap_slot(input logic [6:0] bits, input logic [2:0] len);
		logic [7:0] idx;
		idx = '0;
		for (int i = 0; i < len; i++)
			idx = idx * 8'd2 + (bits[i] ? 8'd2 : 8'd1);
		return idx;
	endfunction

	// letter of the open token
	function automatic logic [7:0] token_letter();
		if (token_slash)
			return CH_SPACE;
		if (token_long || walk_idx >= TABLE_DEPTH)
			return CH_HASH;
		if (tree_letter[walk_idx] == CH_NUL)
			return CH_HASH;
		return tree_letter[walk_idx];
	endfunction

	function automatic void clear_token();
		walk_idx    = '0;
		walk_depth  = 0;
		token_count = 0;
		token_open  = 1'b0;
		token_slash = 1'b0;
		walk_halted = 1'b0;
		token_long  = 1'b0;
	endfunction

	// predict the results of one accepted item and queue them
	task automatic morse_step(input in_item_t it);
		out_item_t  outs [$];
		out_item_t  r;
		logic [7:0] slot;
		logic [7:0] c;
		c = it.ch;
		r = '0;
		if (it.func == FUNC_LOAD) begin
			slot = heap_slot(it.code_bits, it.code_len);
			if (tree_letter[slot] != CH_NUL) begin
				refused = 1'b1;
				r.kind = KIND_DUP;
			end else begin
				tree_letter[slot] = c;
				r.kind = KIND_LOADED;
			end
			outs.push_back(r);
		end else if (!refused) begin
			if (is_space_byte(c)) begin
				// whitespace closes an open token, a newline is echoed after it
				if (token_open) begin
					outs.push_back(out_item_t'{KIND_CHAR, token_letter(), 1'b0});
					clear_token();
					if (c == CH_LF)
						outs.push_back(out_item_t'{KIND_CHAR, CH_LF, 1'b0});
				end
			end else begin
				if (!token_open) begin
					token_open  = 1'b1;
					token_slash = (c == CH_SLASH);
				end
				if (token_count <= MAX_LEN)
					token_count++;
				if (token_count > MAX_LEN)
					token_long = 1'b1;
				// walk the tree until the first symbol that is not a dot or dash
				if (!walk_halted) begin
					if (c != CH_DOT && c != CH_DASH) begin
						walk_halted = 1'b1;
					end else if (walk_depth >= TREE_LEVELS) begin
						token_long  = 1'b1;
						walk_halted = 1'b1;
					end else begin
						walk_idx = walk_idx * 8'd2 + ((c == CH_DASH) ? 8'd2 : 8'd1);
						walk_depth++;
					end
				end
			end
			// end of input flushes an open token
			if (it.final_req && token_open) begin
				outs.push_back(out_item_t'{KIND_CHAR, token_letter(), 1'b0});
				clear_token();
			end
		end
		if (outs.size() > 0) begin
			outs[outs.size() - 1].last = 1'b1;
			foreach (outs[i])
				expected_results.push_back(outs[i]);
		end
	endtask

	task automatic queue_item(input logic func, input logic [7:0] ch, input logic [6:0] bits,
		input logic [2:0] len, input logic fin);
		in_item_t it;
		it.func      = func;
		it.ch        = ch;
		it.code_bits = bits;
		it.code_len  = len;
		it.final_req = fin;
		pending_items.push_back(it);
	endtask

	task automatic queue_load(input logic [6:0] bits, input logic [2:0] len,
		input logic [7:0] letter);
		if (letter != CH_NUL)
			slot_used[heap_slot(bits, len)] = 1'b1;
		queue_item(FUNC_LOAD, letter, bits, len, 1'($urandom));
	endtask

	task automatic queue_byte(input logic [7:0] ch, input logic fin);
		queue_item(FUNC_DECODE, ch, 7'($urandom), 3'($urandom), fin);
	endtask

	// load a slot still empty, mostly in the upper tree
	task automatic queue_fresh_load();
		logic [6:0] bits;
		logic [2:0] len;
		for (int tries = 0; tries < 8; tries++) begin
			bits = 7'($urandom);
			len  = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 4)) :
				3'($urandom_range(0, 7));
			if (!slot_used[heap_slot(bits, len)]) begin
				queue_load(bits, len, ($urandom_range(0, 9) == 0) ? CH_NUL :
					8'($urandom_range(1, 255)));
				return;
			end
		end
	endtask

	// one token of dots and dashes, sometimes long, slashed or broken, then whitespace
	task automatic queue_token();
		int         n;
		int         junk_at;
		logic       slash;
		logic [7:0] c;
		n = ($urandom_range(0, 11) == 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 3) :
			$urandom_range(1, MAX_LEN);
		junk_at = ($urandom_range(0, 14) == 0) ? $urandom_range(0, n - 1) : -1;
		slash   = ($urandom_range(0, 14) == 0);
		for (int i = 0; i < n; i++) begin
			if (slash && i == 0) begin
				c = CH_SLASH;
			end else if (i == junk_at) begin
				do
					c = 8'($urandom);
				while (is_space_byte(c) || c == CH_DOT || c == CH_DASH);
			end else begin
				c = ($urandom_range(0, 1) == 1) ? CH_DASH : CH_DOT;
			end
			if ($urandom_range(0, 24) == 0)
				queue_fresh_load();
			queue_byte(c, (i == n - 1) && $urandom_range(0, 19) == 0);
		end
		repeat ($urandom_range(1, 2))
			queue_byte(blanks[$urandom_range(0, 5)], $urandom_range(0, 19) == 0);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
			send_idle = 0;
		end else begin
			if (push && !full)
				morse_step(item);
			if (!push || !full) begin
				if (send_idle > 0) begin
					send_idle--;
					push <= 1'b0;
				end else if (pending_items.size() == 0) begin
					push <= 1'b0;
				end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
					send_idle = $urandom_range(0, 14);
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					item <= pending_items.pop_front();
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_stall = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result, got kind %0d char %02h last %0b",
							$time, result.kind, result.out_char, result.last);
				end else begin
					want_result = expected_results.pop_front();
					if (result.kind !== want_result.kind ||
						result.out_char !== want_result.out_char ||
						result.last !== want_result.last) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
								$time, want_result.kind, want_result.out_char, want_result.last,
								result.kind, result.out_char, result.last);
					end
				end
			end
			if (pop_stall > 0) begin
				pop_stall--;
				pop <= 1'b0;
			end else if (pending_items.size() > CALM_ITEMS && $urandom_range(0, 9) == 0) begin
				pop_stall = $urandom_range(0, 14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tree_letter[i] = CH_NUL;
			slot_used[i]   = 1'b0;
		end
		clear_token();
		refused = 1'b0;
		blanks  = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

		// directed: pattern bits above the length are ignored, deepest dash leaf
		queue_load(7'h7E, 3'd1, 8'h45);
		queue_load(7'h7F, 3'd7, 8'hFF);
		// loaded letter, then an empty entry closed by newline
		queue_byte(CH_DOT, 1'b0);
		queue_byte(CH_SPACE, 1'b0);
		queue_byte(CH_DASH, 1'b0);
		queue_byte(CH_LF, 1'b0);
		// slash token gives a space
		queue_byte(CH_SLASH, 1'b0);
		queue_byte(CH_DOT, 1'b0);
		queue_byte(CH_TAB, 1'b0);
		// walk stops at an empty root
		queue_byte(8'h78, 1'b0);
		queue_byte(CH_CR, 1'b0);
		// deepest leaf flushed by end of input
		repeat (6)
			queue_byte(CH_DASH, 1'b0);
		queue_byte(CH_DASH, 1'b1);
		// long token with an empty-letter load in the middle
		repeat (4)
			queue_byte(CH_DOT, 1'b0);
		queue_load(7'h05, 3'd3, CH_NUL);
		repeat (4)
			queue_byte(CH_DOT, 1'b0);
		queue_byte(CH_VT, 1'b1);
		// end of input outside a token
		queue_byte(CH_FF, 1'b1);

		// random well-formed text with loads and noise
		while (pending_items.size() < RANDOM_END) begin
			case ($urandom_range(0, 99)) inside
				[0:11]:  queue_fresh_load();
				[12:84]: queue_token();
				default: queue_byte(8'($urandom), $urandom_range(0, 7) == 0);
			endcase
		end

		// duplicate load, after which decoding stays silent
		queue_load(7'h7F, 3'd7, 8'h5A);
		while (pending_items.size() < STREAM_END) begin
			case ($urandom_range(0, 3))
				0:       queue_load(7'($urandom), 3'($urandom), 8'($urandom));
				1, 2:    queue_token();
				default: queue_byte(8'($urandom), 1'($urandom));
			endcase
		end

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || push)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[filelist.f]
design/mtd_pkg.sv
design/mtd_ram.sv
design/mtd_front.sv
design/mtd_queue.sv
design/mtd_back.sv
design/morse_token_decoder_unit.sv
verif/tb_top.sv
